### src/ues_pkg.sv
// ----------------------------------------------------------------------------
// ues_pkg
// Shared constants, codes and controller/datapath interface types for the
// unique-element stack.
// ----------------------------------------------------------------------------
package ues_pkg;

	// stack geometry
	localparam int STACK_DEPTH = 8;
	localparam int DATA_W      = 32;
	localparam int STATUS_W    = 2;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	// request codes
	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

	// kind of result to load into the output register
	typedef enum logic [2:0] {
		RES_PUSH_OK,
		RES_PRESENT,
		RES_OVERFLOW,
		RES_UNDERFLOW,
		RES_POP_OK
	} res_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture request payload, restart scan
		logic scan_rd;    // read entry at scan pointer, advance pointer
		logic rd_top;     // read top entry
		logic wr_found;   // write top data into the matching slot
		logic wr_top;     // write request value into the top slot
		logic append;     // write request value above top, grow
		logic pop;        // shrink by one
		logic res_load;   // load output register
		res_t res_kind;
	} ues_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic full;
		logic empty;
		logic scan_done;  // every stored entry has been read
		logic match;      // entry read last cycle equals the request value
	} ues_sts_t;

endpackage

### src/unique_element_stack.sv
// ----------------------------------------------------------------------------
// unique_element_stack
// Bounded stack of signed 32-bit values holding each value at most once.
// A push of a stored value swaps its lowest copy with the top entry.
// ----------------------------------------------------------------------------
//
//  channel   signals                               role
//  -------   ------------------------------------  ---------------------------
//  in        in_valid/in_ready, action, value      push or pop request
//  out       out_valid/out_ready, popped_value,    one result per request
//            status, was_present
//
//  A push scans the stored entries one per cycle through the single read
//  port of the entry memory and stops at the first match; a stored value
//  is then swapped with the top entry, else the value is appended. Pops,
//  overflows and underflows skip the scan. A new request is taken in the
//  cycle after the result is loaded, even while that result still waits.
//  Reset (arst_n low) empties the stack; entries above the fill count hold
//  stale data that is never read.
//  A stalled output holds the controller in its response state.
//
module unique_element_stack (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                action,
	input  logic signed [ues_pkg::DATA_W-1:0]   value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [ues_pkg::DATA_W-1:0]   popped_value,
	output logic [ues_pkg::STATUS_W-1:0]        status,
	output logic                                was_present
);

	ues_pkg::ues_cmd_t cmd;
	ues_pkg::ues_sts_t sts;

	ues_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	ues_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.value        (value),
		.popped_value (popped_value),
		.status       (status),
		.was_present  (was_present)
	);

endmodule

### src/ues_dp.sv
// ----------------------------------------------------------------------------
// ues_dp
// Datapath: entry memory with registered read, fill count, scan pointer,
// compare, and the output result register.
// ----------------------------------------------------------------------------
module ues_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ues_pkg::ues_cmd_t                   cmd,
	output ues_pkg::ues_sts_t                   sts,
	input  logic signed [ues_pkg::DATA_W-1:0]   value,
	output logic signed [ues_pkg::DATA_W-1:0]   popped_value,
	output logic [ues_pkg::STATUS_W-1:0]        status,
	output logic                                was_present
);

	logic signed [ues_pkg::DATA_W-1:0] mem_q [ues_pkg::STACK_DEPTH];
	logic signed [ues_pkg::DATA_W-1:0] value_q;
	logic signed [ues_pkg::DATA_W-1:0] rdata_s1;
	logic [ues_pkg::CNT_W-1:0]         fill_q;
	logic [ues_pkg::CNT_W-1:0]         scan_q;
	logic [ues_pkg::IDX_W-1:0]         hit_idx_s1;
	logic                              rd_vld_s1;

	logic [ues_pkg::IDX_W-1:0]         top_idx;
	logic [ues_pkg::CNT_W-1:0]         top_cnt;
	logic [ues_pkg::IDX_W-1:0]         rd_addr;
	logic                              wr_en;
	logic [ues_pkg::IDX_W-1:0]         wr_addr;
	logic signed [ues_pkg::DATA_W-1:0] wr_data;

	// address of the current top entry
	assign top_cnt = fill_q - ues_pkg::CNT_W'(1);
	assign top_idx = top_cnt[ues_pkg::IDX_W-1:0];

	// status back to the controller
	assign sts.full      = (fill_q == ues_pkg::CNT_W'(ues_pkg::STACK_DEPTH));
	assign sts.empty     = (fill_q == '0);
	assign sts.scan_done = (scan_q == fill_q);
	assign sts.match     = rd_vld_s1 && (rdata_s1 == value_q);

	// read and write port selection
	always_comb begin
		rd_addr = cmd.scan_rd ? scan_q[ues_pkg::IDX_W-1:0] : top_idx;
		wr_en   = cmd.wr_found || cmd.wr_top || cmd.append;
		if (cmd.wr_found) begin
			wr_addr = hit_idx_s1;
			wr_data = rdata_s1;
		end else if (cmd.wr_top) begin
			wr_addr = top_idx;
			wr_data = value_q;
		end else begin
			wr_addr = fill_q[ues_pkg::IDX_W-1:0];
			wr_data = value_q;
		end
	end

	// entry memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.scan_rd || cmd.rd_top) begin
			rdata_s1 <= mem_q[rd_addr];
		end
		if (cmd.scan_rd) begin
			hit_idx_s1 <= scan_q[ues_pkg::IDX_W-1:0];
		end
		if (cmd.load) begin
			value_q <= value;
		end
	end

	// fill count, scan pointer, read-valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			scan_q    <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_rd;
			if (cmd.load) begin
				scan_q <= '0;
			end else if (cmd.scan_rd) begin
				scan_q <= scan_q + ues_pkg::CNT_W'(1);
			end
			if (cmd.append) begin
				fill_q <= fill_q + ues_pkg::CNT_W'(1);
			end else if (cmd.pop) begin
				fill_q <= top_cnt;
			end
		end
	end

	// output result register
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			unique case (cmd.res_kind)
				ues_pkg::RES_PUSH_OK: begin
					popped_value <= '0;
					status       <= ues_pkg::ST_OK;
					was_present  <= 1'b0;
				end
				ues_pkg::RES_PRESENT: begin
					popped_value <= '0;
					status       <= ues_pkg::ST_OK;
					was_present  <= 1'b1;
				end
				ues_pkg::RES_OVERFLOW: begin
					popped_value <= '0;
					status       <= ues_pkg::ST_OVERFLOW;
					was_present  <= 1'b0;
				end
				ues_pkg::RES_UNDERFLOW: begin
					popped_value <= '1;
					status       <= ues_pkg::ST_UNDERFLOW;
					was_present  <= 1'b0;
				end
				ues_pkg::RES_POP_OK: begin
					popped_value <= rdata_s1;
					status       <= ues_pkg::ST_OK;
					was_present  <= 1'b0;
				end
				default: begin
					popped_value <= '0;
					status       <= ues_pkg::ST_OK;
					was_present  <= 1'b0;
				end
			endcase
		end
	end

endmodule

### src/ues_ctrl.sv
// ----------------------------------------------------------------------------
// ues_ctrl
// Controller: sequences search, swap, append and pop over the datapath and
// owns both handshakes.
// ----------------------------------------------------------------------------
module ues_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              action,
	output logic              out_valid,
	input  logic              out_ready,
	output ues_pkg::ues_cmd_t cmd,
	input  ues_pkg::ues_sts_t sts
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_TOP_RD,
		S_SWAP_LO,
		S_SWAP_HI,
		S_APPEND,
		S_POP_RD,
		S_RESP
	} state_t;

	state_t         state_q;
	state_t         state_d;
	ues_pkg::res_t  res_q;
	ues_pkg::res_t  res_d;
	logic           out_valid_q;
	logic           accept;
	logic           out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// next state and datapath commands
	always_comb begin
		state_d      = state_q;
		res_d        = res_q;
		cmd          = '0;
		cmd.res_kind = res_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					if (action == ues_pkg::ACT_POP) begin
						if (sts.empty) begin
							res_d   = ues_pkg::RES_UNDERFLOW;
							state_d = S_RESP;
						end else begin
							state_d = S_POP_RD;
						end
					end else if (sts.full) begin
						res_d   = ues_pkg::RES_OVERFLOW;
						state_d = S_RESP;
					end else if (sts.empty) begin
						state_d = S_APPEND;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			// one read issued per cycle, compared in the cycle after it is issued
			S_SCAN: begin
				if (sts.match) begin
					state_d = S_TOP_RD;
				end else if (sts.scan_done) begin
					state_d = S_APPEND;
				end else begin
					cmd.scan_rd = 1'b1;
				end
			end
			S_TOP_RD: begin
				cmd.rd_top = 1'b1;
				state_d    = S_SWAP_LO;
			end
			S_SWAP_LO: begin
				cmd.wr_found = 1'b1;
				state_d      = S_SWAP_HI;
			end
			S_SWAP_HI: begin
				cmd.wr_top = 1'b1;
				res_d      = ues_pkg::RES_PRESENT;
				state_d    = S_RESP;
			end
			S_APPEND: begin
				cmd.append = 1'b1;
				res_d      = ues_pkg::RES_PUSH_OK;
				state_d    = S_RESP;
			end
			S_POP_RD: begin
				cmd.rd_top = 1'b1;
				cmd.pop    = 1'b1;
				res_d      = ues_pkg::RES_POP_OK;
				state_d    = S_RESP;
			end
			// wait for the output register to free up
			S_RESP: begin
				if (out_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state, result kind and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_q       <= ues_pkg::RES_PUSH_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### src/ues_checker.sv
// ----------------------------------------------------------------------------
// ues_checker
// Port-level checks for the unique-element stack, bound to the top level.
// ----------------------------------------------------------------------------
module ues_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                action,
	input logic signed [ues_pkg::DATA_W-1:0]   value,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [ues_pkg::DATA_W-1:0]   popped_value,
	input logic [ues_pkg::STATUS_W-1:0]        status,
	input logic                                was_present
);

	// a held result stays put until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(popped_value)
			&& $stable(status) && $stable(was_present))
		else $error("result changed while stalled");

	// one request at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while busy");

	// underflow always returns minus one
	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ues_pkg::ST_UNDERFLOW) |-> (popped_value == -1)
			&& !was_present)
		else $error("bad underflow result");

	// a swap is a successful push with zero data
	a_present: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_present |-> (status == ues_pkg::ST_OK) && (popped_value == 0))
		else $error("bad swap result");

	// overflow carries zero data and no presence flag
	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ues_pkg::ST_OVERFLOW) |-> (popped_value == 0)
			&& !was_present)
		else $error("bad overflow result");

endmodule

bind unique_element_stack ues_checker u_ues_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.action       (action),
	.value        (value),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.popped_value (popped_value),
	.status       (status),
	.was_present  (was_present)
);

### tb/unique_element_stack_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_element_stack_test
// Self-checking bench for the unique-element stack. Push and pop requests go
// in through a valid/ready port while a second process takes the results.
// A behavioral copy of the stack predicts every result, and each result is
// checked field by field in arrival order. Both ports idle at random, and
// one long output stall backs the block up until it stops taking requests.
// ----------------------------------------------------------------------------
module unique_element_stack_test;

	localparam int CLK_PERIOD      = 4;
	localparam int RESET_CYCLES    = 8;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int DRAIN_CYCLES    = 30;
	localparam int WATCHDOG_CYCLES = 250_000;
	localparam int POOL_SIZE       = 12;
	localparam int MAX_REPORTS     = 10;

	typedef struct {
		logic signed [ues_pkg::DATA_W-1:0] popped;
		logic [ues_pkg::STATUS_W-1:0]      st;
		logic                              present;
	} stack_result_t;

	logic                                clk          = 1'b0;
	logic                                arst_n       = 1'b0;
	logic                                in_valid     = 1'b0;
	logic                                in_ready;
	logic                                action       = ues_pkg::ACT_PUSH;
	logic signed [ues_pkg::DATA_W-1:0]   value        = '0;
	logic                                out_valid;
	logic                                out_ready    = 1'b0;
	logic signed [ues_pkg::DATA_W-1:0]   popped_value;
	logic [ues_pkg::STATUS_W-1:0]        status;
	logic                                was_present;

	// predicted stack contents
	logic signed [ues_pkg::DATA_W-1:0]   shadow_mem [ues_pkg::STACK_DEPTH];
	int                                  shadow_fill = 0;
	stack_result_t                       pending_results [$];

	// values reused so that pushes often hit stored entries
	logic signed [ues_pkg::DATA_W-1:0]   value_pool [POOL_SIZE];

	bit tx_idle_en   = 1'b1;
	bit rx_idle_en   = 1'b1;
	bit hold_off_req = 1'b0;

	int mismatches    = 0;
	int n_checked     = 0;
	int cnt_append    = 0;
	int cnt_swap      = 0;
	int cnt_overflow  = 0;
	int cnt_pop       = 0;
	int cnt_underflow = 0;

	unique_element_stack dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.popped_value (popped_value),
		.status       (status),
		.was_present  (was_present)
	);

	always begin
		clk = 1'b0;
		#(CLK_PERIOD / 2);
		clk = 1'b1;
		#(CLK_PERIOD / 2);
	end

	// stack behavior for one accepted request
	function automatic stack_result_t predict_result(input logic act,
			input logic signed [ues_pkg::DATA_W-1:0] val);
		stack_result_t r;
		int slot;
		int i;
		logic signed [ues_pkg::DATA_W-1:0] tmp;
		r.popped  = '0;
		r.st      = ues_pkg::ST_OK;
		r.present = 1'b0;
		slot      = -1;
		if (act == ues_pkg::ACT_PUSH) begin
			if (shadow_fill >= ues_pkg::STACK_DEPTH) begin
				r.st = ues_pkg::ST_OVERFLOW;
				cnt_overflow++;
			end else begin
				// scan from the top down so the lowest copy wins
				for (i = shadow_fill - 1; i >= 0; i--)
					if (shadow_mem[i] == val)
						slot = i;
				if (slot >= 0) begin
					tmp                         = shadow_mem[slot];
					shadow_mem[slot]            = shadow_mem[shadow_fill - 1];
					shadow_mem[shadow_fill - 1] = tmp;
					r.present                   = 1'b1;
					cnt_swap++;
				end else begin
					shadow_mem[shadow_fill] = val;
					shadow_fill++;
					cnt_append++;
				end
			end
		end else begin
			if (shadow_fill == 0) begin
				r.popped = -1;
				r.st     = ues_pkg::ST_UNDERFLOW;
				cnt_underflow++;
			end else begin
				shadow_fill--;
				r.popped = shadow_mem[shadow_fill];
				cnt_pop++;
			end
		end
		return r;
	endfunction

	task automatic flag_error(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	// one request, called at a rising edge; returns at the accepting edge
	task automatic send_request(input logic act,
			input logic signed [ues_pkg::DATA_W-1:0] val);
		int gap;
		gap = 0;
		if (tx_idle_en && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		value    <= val;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_results.push_back(predict_result(act, val));
	endtask

	// pops get likelier as the stack fills; a few land on an empty stack
	task automatic run_traffic(input int count, input bit from_pool);
		logic act;
		logic signed [ues_pkg::DATA_W-1:0] val;
		repeat (count) begin
			if ($urandom_range(0, 9) < shadow_fill || $urandom_range(0, 19) == 0)
				act = ues_pkg::ACT_POP;
			else
				act = ues_pkg::ACT_PUSH;
			if (from_pool)
				val = value_pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				val = $urandom;
			send_request(act, val);
		end
	endtask

	// result checker
	always @(posedge clk) begin : result_check
		stack_result_t want;
		if (arst_n && out_valid && out_ready) begin
			n_checked++;
			if (pending_results.size() == 0) begin
				flag_error($sformatf("unexpected result popped=%0d status=%0d present=%0b",
					popped_value, status, was_present));
			end else begin
				want = pending_results.pop_front();
				if (popped_value !== want.popped)
					flag_error($sformatf("popped_value expected %0d got %0d",
						want.popped, popped_value));
				if (status !== want.st)
					flag_error($sformatf("status expected %0d got %0d",
						want.st, status));
				if (was_present !== want.present)
					flag_error($sformatf("was_present expected %0b got %0b",
						want.present, was_present));
			end
		end
	end

	// result sink: random stall bursts plus one long hold-off on request
	initial begin : result_sink
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				out_ready    <= 1'b1;
				hold_off_req = 1'b0;
			end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// empty-stack pop, field extremes, self swap, deep swap, full stack, drain
	task automatic test_directed_corners();
		send_request(ues_pkg::ACT_POP, $urandom);
		send_request(ues_pkg::ACT_PUSH, 32'sh7FFF_FFFF);
		send_request(ues_pkg::ACT_PUSH, 32'sh8000_0000);
		send_request(ues_pkg::ACT_PUSH, 32'sh0000_0000);
		send_request(ues_pkg::ACT_PUSH, -32'sd1);
		send_request(ues_pkg::ACT_PUSH, -32'sd1);
		send_request(ues_pkg::ACT_PUSH, 32'sh7FFF_FFFF);
		send_request(ues_pkg::ACT_PUSH, 32'sd1);
		send_request(ues_pkg::ACT_PUSH, 32'sd2);
		send_request(ues_pkg::ACT_PUSH, 32'sh5555_5555);
		send_request(ues_pkg::ACT_PUSH, 32'shAAAA_AAAA);
		send_request(ues_pkg::ACT_PUSH, -32'sd1);
		send_request(ues_pkg::ACT_PUSH, 32'sd3);
		repeat (ues_pkg::STACK_DEPTH) send_request(ues_pkg::ACT_POP, $urandom);
		send_request(ues_pkg::ACT_POP, $urandom);
	endtask

	// pushes drawn from a small pool, so swaps are frequent
	task automatic test_swap_sequences();
		int i;
		value_pool[0] = 32'sh7FFF_FFFF;
		value_pool[1] = 32'sh8000_0000;
		value_pool[2] = '0;
		value_pool[3] = -32'sd1;
		for (i = 4; i < POOL_SIZE; i++)
			value_pool[i] = $urandom;
		run_traffic(300, 1'b1);
	endtask

	// long output stall while requests keep coming
	task automatic test_output_backpressure();
		hold_off_req = 1'b1;
		repeat (12) send_request(1'($urandom_range(0, 1)), value_pool[$urandom_range(0, 3)]);
	endtask

	// arbitrary values: mostly appends, overflows and pops
	task automatic test_random_values();
		run_traffic(200, 1'b0);
	endtask

	// back-to-back traffic with no idling on either side
	task automatic test_full_rate();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		run_traffic(120, 1'b1);
	endtask

	initial begin : main
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_corners();
		test_swap_sequences();
		test_output_backpressure();
		test_random_values();
		test_full_rate();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d appends, %0d swaps, %0d overflows, %0d pops, %0d underflows",
			cnt_append, cnt_swap, cnt_overflow, cnt_pop, cnt_underflow);
		$display("%0d results checked, %0d mismatches", n_checked, mismatches);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin : watchdog
		#(WATCHDOG_CYCLES * CLK_PERIOD);
		$display("Timeout with %0d results outstanding", pending_results.size());
		$display("Some tests failed");
		$finish;
	end

endmodule
